/* rtl/itbs_pkg.sv */
package itbs_pkg;

   // Field widths of the two channels and the configuration port.
   localparam int CMD_WIDTH     = 3;
   localparam int BYTE_WIDTH    = 8;
   localparam int ADDR7_WIDTH   = 7;
   localparam int KIND_WIDTH    = 2;
   localparam int TOTAL_WIDTH   = 6;

   // Default size of the receive and transmit byte buffer.
   localparam int BUFFER_DEPTH_DEFAULT = 32;

   // Values loaded into the bus shift register.
   localparam logic [BYTE_WIDTH-1:0] ACK_BYTE  = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] NACK_BYTE = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] IDLE_BYTE = 8'hFF;

   // Bus events and local commands carried by an input item.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_START     = 3'd0,
      CMD_STOP      = 3'd1,
      CMD_SHIFT     = 3'd2,
      CMD_TX_WRITE  = 3'd3,
      CMD_FILL_DONE = 3'd4
   } cmd_type;

   // Kind of a result item.
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LINE    = 2'd0,
      KIND_APP     = 2'd1,
      KIND_REQUEST = 2'd2
   } kind_type;

   // Bus transfer phase of the target.
   typedef enum logic [3:0] {
      PH_STOPPED      = 4'd0,
      PH_VERIFY       = 4'd1,
      PH_IGNORE       = 4'd2,
      PH_REQ_DATA     = 4'd3,
      PH_RECV         = 4'd4,
      PH_SLAVE_ABORT  = 4'd5,
      PH_SEND         = 4'd6,
      PH_GET_RESP     = 4'd7,
      PH_EVAL         = 4'd8,
      PH_MASTER_ABORT = 4'd9,
      PH_AWAIT_FILL   = 4'd10
   } phase_type;

   // States of the item sequencer.
   typedef enum logic [2:0] {
      ENG_IDLE      = 3'd0,
      ENG_SEND_RD   = 3'd1,
      ENG_SEND_PUT  = 3'd2,
      ENG_DRAIN_RD  = 3'd3,
      ENG_DRAIN_PUT = 3'd4,
      ENG_FINAL     = 3'd5
   } engine_type;

   // Result templates that the datapath can load into the output register.
   typedef enum logic [2:0] {
      RES_ZERO   = 3'd0,
      RES_LISTEN = 3'd1,
      RES_ACK    = 3'd2,
      RES_NACK   = 3'd3,
      RES_REQ    = 3'd4,
      RES_GET    = 3'd5,
      RES_SEND   = 3'd6,
      RES_APP    = 3'd7
   } res_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      res_type res;
      logic    capture_mr;
      logic    store_byte;
      logic    clear_counts;
      logic    drain_clear;
      logic    drain_step;
      logic    rd_send;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic addr_match;
      logic data_lsb;
      logic master_reads;
      logic fill_zero;
      logic fill_full;
      logic drain_last;
      logic out_free;
   } dp_stat_type;

   // One result item as held in the output register.
   typedef struct packed {
      kind_type                kind;
      logic                    load_shift;
      logic [BYTE_WIDTH-1:0]   shift_value;
      logic                    drive_sda;
      logic                    count_one_bit;
      logic                    listen_only;
      logic [BYTE_WIDTH-1:0]   app_byte;
      logic [TOTAL_WIDTH-1:0]  byte_total;
      logic                    last;
   } res_payload_type;

   // Address width of a memory of the given depth, at least one bit.
   function automatic int itbs_addr_width(input int depth);
      int w;
      begin
         w = (depth > 1) ? $clog2(depth) : 1;
         return w;
      end
   endfunction

endpackage

/* rtl/itbs_channels.sv */
// Input channel: bus events and transmit buffer commands.
interface itbs_req_if import itbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_WIDTH-1:0]  cmd;
   logic [BYTE_WIDTH-1:0] data;

   modport source (output valid, cmd, data, input ready);
   modport sink (input valid, cmd, data, output ready);
endinterface

// Result channel: line control, received bytes and data requests.
interface itbs_rsp_if import itbs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_WIDTH-1:0]  kind;
   logic                   load_shift;
   logic [BYTE_WIDTH-1:0]  shift_value;
   logic                   drive_sda;
   logic                   count_one_bit;
   logic                   listen_only;
   logic [BYTE_WIDTH-1:0]  app_byte;
   logic [TOTAL_WIDTH-1:0] byte_total;
   logic                   last;

   modport source (output valid, kind, load_shift, shift_value, drive_sda, count_one_bit,
                   listen_only, app_byte, byte_total, last, input ready);
   modport sink (input valid, kind, load_shift, shift_value, drive_sda, count_one_bit,
                 listen_only, app_byte, byte_total, last, output ready);
endinterface

/* rtl/i2c_target_byte_sequencer.sv */
// Channel  Role      Handshake          Payload
// req      sink      valid / ready      cmd, data
// rsp      source    valid / ready      kind, load_shift, shift_value, drive_sda,
//                                       count_one_bit, listen_only, app_byte,
//                                       byte_total, last
// csr      write     csr_write_en       csr_write_data (own address)
//
// An item with one line-control result shows its result the next cycle.
// A byte send passes through ENG_SEND_RD and ENG_SEND_PUT, for the registered read of the byte buffer.
// A drain passes through ENG_DRAIN_RD, ENG_DRAIN_PUT once per byte, then ENG_FINAL, and stalls while rsp is not ready.
// Reset is synchronous and active high; the buffer needs no clearing pass.
// req.ready is low while a drain or send runs or while a result stalls in the output register.
module i2c_target_byte_sequencer import itbs_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   itbs_req_if.sink               req_chan,
   itbs_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [ADDR7_WIDTH-1:0] csr_write_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        req_accept;

   assign req_accept = req_chan.valid && req_chan.ready;

   itbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .stat  (dp_stat),
      .cmd   (dp_cmd)
   );

   itbs_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_chan.data),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .rsp            (rsp_chan)
   );

   // A received byte handed to the application is never the final result of its item.
   a_app_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_APP)) |-> !rsp_chan.last)
      else $error("received byte result marked as last");

   // Start or stop in a read transfer has nothing to drain: line control comes next cycle.
   a_no_drain_on_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && dp_stat.master_reads &&
       ((req_chan.cmd == CMD_START) || (req_chan.cmd == CMD_STOP)))
      |=> (rsp_chan.valid && rsp_chan.last && (rsp_chan.kind == KIND_LINE)))
      else $error("start or stop in read transfer did not give line control");

   // A transmit byte write never brings up a result.
   a_tx_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_chan.cmd == CMD_TX_WRITE)) |=> !$rose(rsp_chan.valid))
      else $error("transmit byte write produced a result");

endmodule

/* rtl/itbs_ram.sv */
module itbs_ram import itbs_pkg::*; #(
   parameter int WIDTH = BYTE_WIDTH,
   parameter int DEPTH = BUFFER_DEPTH_DEFAULT,
   localparam int AW = itbs_addr_width(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/itbs_datapath.sv */
module itbs_datapath import itbs_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [ADDR7_WIDTH-1:0] csr_write_data,
   input  logic [BYTE_WIDTH-1:0]  req_data,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   itbs_rsp_if.source             rsp
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int AW = itbs_addr_width(BUFFER_DEPTH);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(BUFFER_DEPTH);

   logic [ADDR7_WIDTH-1:0] own_addr_ff, own_addr_in;
   logic                   master_reads_ff, master_reads_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [CW-1:0]          send_ff, send_in;
   logic [CW-1:0]          drain_ff, drain_in;
   logic                   valid_ff, valid_in;
   res_payload_type        res_ff, res_in;

   logic [CW-1:0]         drain_next;
   logic                  send_avail;
   logic [AW-1:0]         rd_addr;
   logic [BYTE_WIDTH-1:0] rd_data;

   // Byte buffer, shared by the receive and the transmit direction.
   itbs_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign drain_next = drain_ff + 1'b1;
   assign send_avail = (send_ff < fill_ff);

   // The drain reads one entry ahead so that a byte can leave every cycle while the output register is free.
   always_comb begin
      if (cmd.rd_send) begin
         rd_addr = send_ff[AW-1:0];
      end else if (cmd.drain_step) begin
         rd_addr = drain_next[AW-1:0];
      end else begin
         rd_addr = drain_ff[AW-1:0];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.addr_match   = (own_addr_ff != '0) && (req_data[BYTE_WIDTH-1:1] == own_addr_ff);
      stat.data_lsb     = req_data[0];
      stat.master_reads = master_reads_ff;
      stat.fill_zero    = (fill_ff == '0);
      stat.fill_full    = (fill_ff == DEPTH_COUNT);
      stat.drain_last   = (drain_next == fill_ff);
      stat.out_free     = !valid_ff || rsp.ready;
   end

   // Build the result selected by the controller.
   always_comb begin
      res_in      = '0;
      res_in.kind = KIND_LINE;
      res_in.last = 1'b1;
      case (cmd.res)
         RES_ZERO: begin
         end
         RES_LISTEN: begin
            res_in.listen_only = 1'b1;
         end
         RES_ACK: begin
            res_in.load_shift    = 1'b1;
            res_in.shift_value   = ACK_BYTE;
            res_in.drive_sda     = 1'b1;
            res_in.count_one_bit = 1'b1;
         end
         RES_NACK: begin
            res_in.load_shift    = 1'b1;
            res_in.shift_value   = NACK_BYTE;
            res_in.drive_sda     = 1'b1;
            res_in.count_one_bit = 1'b1;
         end
         RES_REQ: begin
            res_in.kind = KIND_REQUEST;
         end
         RES_GET: begin
            res_in.count_one_bit = 1'b1;
         end
         RES_SEND: begin
            res_in.load_shift  = 1'b1;
            res_in.drive_sda   = 1'b1;
            res_in.shift_value = send_avail ? rd_data : IDLE_BYTE;
         end
         RES_APP: begin
            res_in.kind       = KIND_APP;
            res_in.app_byte   = rd_data;
            res_in.byte_total = TOTAL_WIDTH'(fill_ff);
            res_in.last       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Next values of the counters, flags and output valid.
   always_comb begin
      own_addr_in     = csr_write_en ? csr_write_data : own_addr_ff;
      master_reads_in = cmd.capture_mr ? req_data[0] : master_reads_ff;

      fill_in = fill_ff;
      if (cmd.clear_counts) begin
         fill_in = '0;
      end else if (cmd.store_byte) begin
         fill_in = fill_ff + 1'b1;
      end

      send_in = send_ff;
      if (cmd.clear_counts) begin
         send_in = '0;
      end else if (cmd.load && (cmd.res == RES_SEND) && send_avail) begin
         send_in = send_ff + 1'b1;
      end

      drain_in = drain_ff;
      if (cmd.drain_clear) begin
         drain_in = '0;
      end else if (cmd.drain_step) begin
         drain_in = drain_next;
      end

      valid_in = valid_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff     <= '0;
         master_reads_ff <= 1'b0;
         fill_ff         <= '0;
         send_ff         <= '0;
         drain_ff        <= '0;
         valid_ff        <= 1'b0;
      end else begin
         own_addr_ff     <= own_addr_in;
         master_reads_ff <= master_reads_in;
         fill_ff         <= fill_in;
         send_ff         <= send_in;
         drain_ff        <= drain_in;
         valid_ff        <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.kind          = res_ff.kind;
   assign rsp.load_shift    = res_ff.load_shift;
   assign rsp.shift_value   = res_ff.shift_value;
   assign rsp.drive_sda     = res_ff.drive_sda;
   assign rsp.count_one_bit = res_ff.count_one_bit;
   assign rsp.listen_only   = res_ff.listen_only;
   assign rsp.app_byte      = res_ff.app_byte;
   assign rsp.byte_total    = res_ff.byte_total;
   assign rsp.last          = res_ff.last;

endmodule

/* rtl/itbs_ctrl.sv */
module itbs_ctrl import itbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   itbs_req_if.sink    req,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   engine_type state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic       is_start_ff, is_start_in;
   logic       accept;

   assign req.ready = (state_ff == ENG_IDLE) && stat.out_free;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         phase_ff    <= PH_STOPPED;
         is_start_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         is_start_ff <= is_start_in;
      end
   end

   // Next state, bus phase and datapath commands.
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      is_start_in = is_start_ff;
      cmd         = '0;
      cmd.res     = RES_ZERO;

      case (state_ff)
         ENG_IDLE: begin
            if (accept) begin
               case (cmd_type'(req.cmd))
                  CMD_START, CMD_STOP: begin
                     is_start_in = (cmd_type'(req.cmd) == CMD_START);
                     if (!stat.master_reads && !stat.fill_zero) begin
                        // Received bytes go to the application first.
                        cmd.drain_clear = 1'b1;
                        state_in        = ENG_DRAIN_RD;
                     end else begin
                        cmd.load         = 1'b1;
                        cmd.clear_counts = 1'b1;
                        if (is_start_in) begin
                           cmd.res  = RES_ZERO;
                           phase_in = PH_VERIFY;
                        end else begin
                           cmd.res  = RES_LISTEN;
                           phase_in = PH_STOPPED;
                        end
                     end
                  end
                  CMD_SHIFT: begin
                     case (phase_ff)
                        PH_VERIFY: begin
                           cmd.load = 1'b1;
                           if (stat.addr_match) begin
                              cmd.capture_mr = 1'b1;
                              if (!stat.data_lsb) begin
                                 cmd.res  = RES_ACK;
                                 phase_in = PH_REQ_DATA;
                              end else begin
                                 cmd.res  = RES_REQ;
                                 phase_in = PH_AWAIT_FILL;
                              end
                           end else begin
                              cmd.res  = RES_LISTEN;
                              phase_in = PH_IGNORE;
                           end
                        end
                        PH_REQ_DATA: begin
                           cmd.load = 1'b1;
                           cmd.res  = RES_ZERO;
                           phase_in = PH_RECV;
                        end
                        PH_RECV: begin
                           cmd.load = 1'b1;
                           if (!stat.fill_full) begin
                              cmd.store_byte = 1'b1;
                              cmd.res        = RES_ACK;
                              phase_in       = PH_REQ_DATA;
                           end else begin
                              cmd.res  = RES_NACK;
                              phase_in = PH_SLAVE_ABORT;
                           end
                        end
                        PH_SEND: begin
                           state_in = ENG_SEND_RD;
                        end
                        PH_GET_RESP: begin
                           cmd.load = 1'b1;
                           cmd.res  = RES_GET;
                           phase_in = PH_EVAL;
                        end
                        PH_EVAL: begin
                           // The master's ACK asks for the next byte.
                           if (!stat.data_lsb) begin
                              state_in = ENG_SEND_RD;
                           end else begin
                              cmd.load = 1'b1;
                              cmd.res  = RES_LISTEN;
                              phase_in = PH_MASTER_ABORT;
                           end
                        end
                        default: begin
                           cmd.load = 1'b1;
                           cmd.res  = RES_LISTEN;
                        end
                     endcase
                  end
                  CMD_TX_WRITE: begin
                     cmd.store_byte = stat.master_reads && !stat.fill_full;
                  end
                  CMD_FILL_DONE: begin
                     if (phase_ff == PH_AWAIT_FILL) begin
                        cmd.load = 1'b1;
                        if (stat.fill_zero) begin
                           cmd.res  = RES_LISTEN;
                           phase_in = PH_IGNORE;
                        end else begin
                           cmd.res  = RES_ACK;
                           phase_in = PH_SEND;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ENG_SEND_RD: begin
            cmd.rd_send = 1'b1;
            state_in    = ENG_SEND_PUT;
         end
         ENG_SEND_PUT: begin
            cmd.rd_send = 1'b1;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.res  = RES_SEND;
               phase_in = PH_GET_RESP;
               state_in = ENG_IDLE;
            end
         end
         ENG_DRAIN_RD: begin
            state_in = ENG_DRAIN_PUT;
         end
         ENG_DRAIN_PUT: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.res  = RES_APP;
               if (stat.drain_last) begin
                  state_in = ENG_FINAL;
               end else begin
                  cmd.drain_step = 1'b1;
               end
            end
         end
         ENG_FINAL: begin
            if (stat.out_free) begin
               cmd.load         = 1'b1;
               cmd.clear_counts = 1'b1;
               state_in         = ENG_IDLE;
               if (is_start_ff) begin
                  cmd.res  = RES_ZERO;
                  phase_in = PH_VERIFY;
               end else begin
                  cmd.res  = RES_LISTEN;
                  phase_in = PH_STOPPED;
               end
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import itbs_pkg::*;

   localparam int DEPTH = BUFFER_DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 36;
   localparam int NUM_PHASES = 6;

   // Command codes that the block does not define.
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE7 = 3'd7;

   // Line-control and request results that can be read off directly.
   localparam res_payload_type LINE_IDLE =
      '{kind: KIND_LINE, last: 1'b1, default: '0};
   localparam res_payload_type LINE_RELEASE =
      '{kind: KIND_LINE, listen_only: 1'b1, last: 1'b1, default: '0};
   localparam res_payload_type LINE_ACK =
      '{kind: KIND_LINE, load_shift: 1'b1, shift_value: ACK_BYTE, drive_sda: 1'b1,
        count_one_bit: 1'b1, last: 1'b1, default: '0};
   localparam res_payload_type LINE_NACK =
      '{kind: KIND_LINE, load_shift: 1'b1, shift_value: NACK_BYTE, drive_sda: 1'b1,
        count_one_bit: 1'b1, last: 1'b1, default: '0};
   localparam res_payload_type LINE_GETRESP =
      '{kind: KIND_LINE, count_one_bit: 1'b1, last: 1'b1, default: '0};
   localparam res_payload_type LINE_SEND_FF =
      '{kind: KIND_LINE, load_shift: 1'b1, shift_value: IDLE_BYTE, drive_sda: 1'b1,
        last: 1'b1, default: '0};
   localparam res_payload_type DATA_REQUEST =
      '{kind: KIND_REQUEST, last: 1'b1, default: '0};

   // One row of the directed script: an address write or an input item.
   typedef struct packed {
      logic                  addr_write;
      logic [CMD_WIDTH-1:0]  cmd;
      logic [BYTE_WIDTH-1:0] data;
      logic                  typed;
      res_payload_type       want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [ADDR7_WIDTH-1:0] csr_write_data;

   itbs_req_if req_bus ();
   itbs_rsp_if rsp_bus ();

   i2c_target_byte_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted state of the target.
   logic [ADDR7_WIDTH-1:0] target_addr;
   phase_type              bus_phase;
   logic                   reading;
   logic [BYTE_WIDTH-1:0]  byte_buf [DEPTH];
   int                     fill_level;
   int                     send_ptr;

   res_payload_type pending_rsp [$];
   res_payload_type last_pushed;
   int  last_pushes = 0;
   int  errors = 0;
   int  items_with_results = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   bit  hold_rsp = 1'b0;

   script_row_type directed_script [0:28] = '{
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_RELEASE},
      '{1'b0, CMD_TX_WRITE,  8'h5A, 1'b0, LINE_IDLE},
      '{1'b0, CMD_FILL_DONE, 8'hC3, 1'b0, LINE_IDLE},
      '{1'b0, CMD_SPARE5,    8'hFF, 1'b0, LINE_IDLE},
      '{1'b0, CMD_SPARE7,    8'h80, 1'b0, LINE_IDLE},
      '{1'b0, CMD_START,     8'h00, 1'b1, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_RELEASE},
      '{1'b0, CMD_STOP,      8'hFF, 1'b1, LINE_RELEASE},
      '{1'b1, CMD_START,     8'h7F, 1'b0, LINE_IDLE},
      '{1'b0, CMD_START,     8'h00, 1'b1, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'hFE, 1'b1, LINE_ACK},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'hFF, 1'b1, LINE_ACK},
      '{1'b0, CMD_SHIFT,     8'hFF, 1'b1, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_ACK},
      '{1'b0, CMD_START,     8'h00, 1'b0, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'hFF, 1'b1, DATA_REQUEST},
      '{1'b0, CMD_TX_WRITE,  8'hA5, 1'b0, LINE_IDLE},
      '{1'b0, CMD_TX_WRITE,  8'h00, 1'b0, LINE_IDLE},
      '{1'b0, CMD_FILL_DONE, 8'h00, 1'b1, LINE_ACK},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b0, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_GETRESP},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b0, LINE_IDLE},
      '{1'b0, CMD_SHIFT,     8'hFF, 1'b1, LINE_GETRESP},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_SEND_FF},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_GETRESP},
      '{1'b0, CMD_SHIFT,     8'h01, 1'b1, LINE_RELEASE},
      '{1'b0, CMD_SHIFT,     8'h00, 1'b1, LINE_RELEASE},
      '{1'b0, CMD_STOP,      8'h00, 1'b1, LINE_RELEASE}
   };

   // Print one line per mismatch and count it; printing stops after 50 errors.
   task automatic report_error(input string msg);
      errors++;
      if (errors <= 50)
         $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Queue the next transmit byte, or the idle value once the buffer is used up.
   task automatic send_byte();
      res_payload_type r;
      r = LINE_SEND_FF;
      bus_phase = PH_GET_RESP;
      if (send_ptr < fill_level && send_ptr < DEPTH) begin
         r.shift_value = byte_buf[send_ptr];
         send_ptr++;
      end
      pending_rsp.push_back(r);
   endtask

   // Advance the predicted target by one accepted item and queue its results.
   task automatic advance_target(input logic [CMD_WIDTH-1:0] cmd,
                                 input logic [BYTE_WIDTH-1:0] data);
      res_payload_type r;
      case (cmd)
         CMD_START, CMD_STOP: begin
            if (!reading) begin
               for (int i = 0; i < fill_level && i < DEPTH; i++) begin
                  r = '{kind: KIND_APP, app_byte: byte_buf[i],
                        byte_total: TOTAL_WIDTH'(fill_level), default: '0};
                  pending_rsp.push_back(r);
               end
            end
            fill_level = 0;
            send_ptr = 0;
            if (cmd == CMD_START) begin
               bus_phase = PH_VERIFY;
               pending_rsp.push_back(LINE_IDLE);
            end else begin
               bus_phase = PH_STOPPED;
               pending_rsp.push_back(LINE_RELEASE);
            end
         end
         CMD_SHIFT: begin
            case (bus_phase)
               PH_VERIFY: begin
                  if (target_addr != '0 && data[7:1] == target_addr) begin
                     reading = data[0];
                     if (!reading) begin
                        bus_phase = PH_REQ_DATA;
                        pending_rsp.push_back(LINE_ACK);
                     end else begin
                        bus_phase = PH_AWAIT_FILL;
                        pending_rsp.push_back(DATA_REQUEST);
                     end
                  end else begin
                     bus_phase = PH_IGNORE;
                     pending_rsp.push_back(LINE_RELEASE);
                  end
               end
               PH_REQ_DATA: begin
                  bus_phase = PH_RECV;
                  pending_rsp.push_back(LINE_IDLE);
               end
               PH_RECV: begin
                  if (fill_level < DEPTH) begin
                     byte_buf[fill_level] = data;
                     fill_level++;
                     bus_phase = PH_REQ_DATA;
                     pending_rsp.push_back(LINE_ACK);
                  end else begin
                     bus_phase = PH_SLAVE_ABORT;
                     pending_rsp.push_back(LINE_NACK);
                  end
               end
               PH_SEND: send_byte();
               PH_GET_RESP: begin
                  bus_phase = PH_EVAL;
                  pending_rsp.push_back(LINE_GETRESP);
               end
               PH_EVAL: begin
                  if (!data[0]) begin
                     send_byte();
                  end else begin
                     bus_phase = PH_MASTER_ABORT;
                     pending_rsp.push_back(LINE_RELEASE);
                  end
               end
               default: pending_rsp.push_back(LINE_RELEASE);
            endcase
         end
         CMD_TX_WRITE: begin
            if (reading && fill_level < DEPTH) begin
               byte_buf[fill_level] = data;
               fill_level++;
            end
         end
         CMD_FILL_DONE: begin
            if (bus_phase == PH_AWAIT_FILL) begin
               if (fill_level == 0) begin
                  bus_phase = PH_IGNORE;
                  pending_rsp.push_back(LINE_RELEASE);
               end else begin
                  bus_phase = PH_SEND;
                  pending_rsp.push_back(LINE_ACK);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Random idle length: mostly short, a few long.
   function automatic int stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item, wait for acceptance, predict, then maybe idle.
   task automatic send_item(input logic [CMD_WIDTH-1:0] cmd,
                            input logic [BYTE_WIDTH-1:0] data);
      int before_count;
      int gap;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.cmd = cmd;
      req_bus.data = data;
      do
         @(posedge clock);
      while (!req_bus.ready);
      before_count = pending_rsp.size();
      advance_target(cmd, data);
      last_pushes = pending_rsp.size() - before_count;
      if (last_pushes > 0) begin
         items_with_results++;
         last_pushed = pending_rsp[$];
      end
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) < 45)
         gap = stall_len();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop offering items and wait until every expected result has come.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the own address register while the block is idle.
   task automatic set_target_address(input logic [ADDR7_WIDTH-1:0] addr);
      wait_idle();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = addr;
      @(negedge clock);
      csr_write_en = 1'b0;
      target_addr = addr;
   endtask

   // Address byte: mostly our own address, sometimes any address.
   function automatic logic [BYTE_WIDTH-1:0] address_byte(input logic rd);
      logic [ADDR7_WIDTH-1:0] a;
      a = ($urandom_range(0, 99) < 80) ? target_addr : ADDR7_WIDTH'($urandom);
      return {a, rd};
   endfunction

   // Any command code, the undefined ones included.
   function automatic logic [CMD_WIDTH-1:0] CMD_CMD_NOISE();
      return CMD_WIDTH'($urandom_range(0, 7));
   endfunction

   // Master write: address, then pairs of acknowledge shift and data shift.
   task automatic write_transfer(input int nbytes);
      send_item(CMD_START, BYTE_WIDTH'($urandom));
      send_item(CMD_SHIFT, address_byte(1'b0));
      for (int i = 0; i < nbytes; i++) begin
         send_item(CMD_SHIFT, BYTE_WIDTH'($urandom));
         if ($urandom_range(0, 99) < 3)
            send_item(CMD_CMD_NOISE(), BYTE_WIDTH'($urandom));
         send_item(CMD_SHIFT, BYTE_WIDTH'($urandom));
      end
      if ($urandom_range(0, 1))
         send_item(CMD_STOP, BYTE_WIDTH'($urandom));
   endtask

   // Master read: address, buffer fill, then sends acknowledged until the last one.
   task automatic read_transfer();
      int r;
      int nfill;
      int nsend;
      r = $urandom_range(0, 99);
      if (r < 10)
         nfill = 0;
      else if (r < 85)
         nfill = $urandom_range(1, 5);
      else if (r < 95)
         nfill = $urandom_range(6, 12);
      else
         nfill = $urandom_range(31, 35);
      nsend = $urandom_range(1, (nfill > 8 ? 8 : nfill) + 2);
      send_item(CMD_START, BYTE_WIDTH'($urandom));
      send_item(CMD_SHIFT, address_byte(1'b1));
      for (int i = 0; i < nfill; i++)
         send_item(CMD_TX_WRITE, BYTE_WIDTH'($urandom));
      send_item(CMD_FILL_DONE, BYTE_WIDTH'($urandom));
      for (int i = 0; i < nsend; i++) begin
         send_item(CMD_SHIFT, BYTE_WIDTH'($urandom));
         send_item(CMD_SHIFT, BYTE_WIDTH'($urandom));
         send_item(CMD_SHIFT, {(BYTE_WIDTH-1)'($urandom), 1'(i == nsend - 1)});
      end
      if ($urandom_range(0, 99) < 60)
         send_item(CMD_STOP, BYTE_WIDTH'($urandom));
   endtask

   // Result channel: random back-pressure, and one long hold when asked.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready = 1'b0;
            for (int c = 1; c < HOLD_CYCLES; c++)
               @(negedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 99) < 25) begin
            rsp_bus.ready = 1'b0;
            repeat (stall_len() - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      res_payload_type got;
      res_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind = kind_type'(rsp_bus.kind);
         got.load_shift = rsp_bus.load_shift;
         got.shift_value = rsp_bus.shift_value;
         got.drive_sda = rsp_bus.drive_sda;
         got.count_one_bit = rsp_bus.count_one_bit;
         got.listen_only = rsp_bus.listen_only;
         got.app_byte = rsp_bus.app_byte;
         got.byte_total = rsp_bus.byte_total;
         got.last = rsp_bus.last;
         if (pending_rsp.size() == 0) begin
            report_error($sformatf("result with nothing expected: %h", got));
         end else begin
            want = pending_rsp.pop_front();
            if (got.kind !== want.kind)
               report_error($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.load_shift !== want.load_shift)
               report_error($sformatf("load_shift %0b, expected %0b",
                                      got.load_shift, want.load_shift));
            if (got.shift_value !== want.shift_value)
               report_error($sformatf("shift_value %h, expected %h",
                                      got.shift_value, want.shift_value));
            if (got.drive_sda !== want.drive_sda)
               report_error($sformatf("drive_sda %0b, expected %0b",
                                      got.drive_sda, want.drive_sda));
            if (got.count_one_bit !== want.count_one_bit)
               report_error($sformatf("count_one_bit %0b, expected %0b",
                                      got.count_one_bit, want.count_one_bit));
            if (got.listen_only !== want.listen_only)
               report_error($sformatf("listen_only %0b, expected %0b",
                                      got.listen_only, want.listen_only));
            if (got.app_byte !== want.app_byte)
               report_error($sformatf("app_byte %h, expected %h",
                                      got.app_byte, want.app_byte));
            if (got.byte_total !== want.byte_total)
               report_error($sformatf("byte_total %0d, expected %0d",
                                      got.byte_total, want.byte_total));
            if (got.last !== want.last)
               report_error($sformatf("last %0b, expected %0b", got.last, want.last));
         end
      end
   end

   // Main sequence: reset, directed script, then random transfers.
   initial begin
      int r;
      int phase_goal;
      logic [ADDR7_WIDTH-1:0] addr;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_START;
      req_bus.data = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      target_addr = '0;
      bus_phase = PH_STOPPED;
      reading = 1'b0;
      fill_level = 0;
      send_ptr = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed script; typed rows must match the predictor as well.
      for (int i = 0; i < $size(directed_script); i++) begin
         if (directed_script[i].addr_write) begin
            set_target_address(directed_script[i].data[ADDR7_WIDTH-1:0]);
         end else begin
            send_item(directed_script[i].cmd, directed_script[i].data);
            if (directed_script[i].typed &&
                (last_pushes != 1 || last_pushed != directed_script[i].want))
               report_error($sformatf("directed row %0d predicts a different result", i));
         end
      end

      // Random phases, each at its own address.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: addr = 7'h01;
            2: addr = 7'h7F;
            3: addr = '0;
            default: addr = ADDR7_WIDTH'($urandom_range(1, 127));
         endcase
         set_target_address(addr);
         req_gaps_on = (ph != 2);
         rsp_gaps_on = (ph != 2);
         phase_goal = items_with_results + PHASE_ITEMS;
         if (ph == 4) begin
            // Long receiver hold during a full-buffer write and its drain.
            hold_rsp = 1'b1;
            write_transfer(DEPTH);
            send_item(CMD_START, '0);
         end
         while (items_with_results < phase_goal) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               r = $urandom_range(0, 99);
               if (r < 80)
                  write_transfer($urandom_range(0, 5));
               else if (r < 92)
                  write_transfer($urandom_range(6, 12));
               else
                  write_transfer($urandom_range(30, 34));
            end else if (r < 80) begin
               read_transfer();
            end else begin
               repeat ($urandom_range(1, 4))
                  send_item(CMD_CMD_NOISE(), BYTE_WIDTH'($urandom));
            end
            if (ph == 1 && items_with_results >= phase_goal - PHASE_ITEMS / 2 &&
                items_with_results < phase_goal - PHASE_ITEMS / 2 + 8)
               wait_idle();
         end
      end

      wait_idle();
      if (pending_rsp.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_rsp.size()));
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
